@@ hdl/diff_drive_wheel_speed_pid_defines.svh @@
// Assertion macros used by the port-level checker.
`ifndef DIFF_DRIVE_WHEEL_SPEED_PID_DEFINES_SVH
`define DIFF_DRIVE_WHEEL_SPEED_PID_DEFINES_SVH

// next-cycle implication, masked while reset is high
`define DDWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always active
`define DDWS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ddws_pkg.sv @@
// Package: types and constants of the wheel speed PID block.
`timescale 1ns / 1ps
package ddws_pkg;

   localparam int MUL_A_W = 56;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = 88;
   localparam int NUM_W   = 88;
   localparam int DEN_W   = 60;
   localparam int QUO_W   = 41;

   // 10^6 * round(2*pi*2^32)
   localparam logic [54:0] EST_C = 55'd26986075409000000;
   localparam logic [QUO_W-1:0] EST_CAP = 41'h10000000000;
   localparam logic [DEN_W-1:0] MILLION = 60'd1000000;

   typedef enum logic [1:0] {
      OP_TWIST = 2'd0,
      OP_LEFT  = 2'd1,
      OP_RIGHT = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_GAINS_LEFT  = 3'd0,
      REG_GAINS_RIGHT = 3'd1,
      REG_RATE_LIMIT  = 3'd2,
      REG_INT_CAP     = 3'd3,
      REG_INV_RADIUS  = 3'd4,
      REG_HALF_TRACK  = 3'd5,
      REG_CPR         = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HW, ST_DES, ST_EST_DEN, ST_EST_NUM, ST_EST_DIV, ST_ERR,
      ST_INT_MUL, ST_INT_DIV, ST_P, ST_I, ST_D, ST_FIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic signed [15:0]  lin_speed;
      logic signed [15:0]  ang_speed;
      logic signed [31:0]  encoder_count;
      logic [19:0]         elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive_left;
      logic signed [31:0] drive_right;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

@@ hdl/diff_drive_wheel_speed_pid.sv @@
// Top level: differential drive wheel speed PID with serial multiply and divide units.
// Twist and encoder beats give no result. A tick beat's result comes from the
// bit-serial multiplier and the restoring divider, both shared by the two wheels;
// the rate estimate is skipped when elapsed_us or counts_per_rev is 0, and the
// PID products when a desired rate is 0.
// One tick at a time; synchronous reset loads config and controller registers.
`timescale 1ns / 1ps
module diff_drive_wheel_speed_pid #(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ddws_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ddws_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);
   import ddws_pkg::*;

   localparam int CB     = COUNT_BITS;
   localparam int DES_W  = FRAC_BITS + 10;   // holds +-rate_limit at any FRAC_BITS
   localparam int DES_SH = 36 - FRAC_BITS;
   localparam int DEN_SH = 32 - FRAC_BITS;
   localparam int LIM_SH = FRAC_BITS - 8;

   // ---------------- configuration registers ----------------
   logic [47:0] gains_l_ff, gains_r_ff;
   logic [15:0] rate_lim_ff, inv_r_ff, half_tr_ff, cpr_ff;
   logic [30:0] icap_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_l_ff  <= '0;
         gains_r_ff  <= '0;
         rate_lim_ff <= 16'd65535;
         icap_ff     <= 31'h7fffffff;
         inv_r_ff    <= 16'd5120;
         half_tr_ff  <= 16'd7209;
         cpr_ff      <= 16'd1185;
      end else if (csr_wr) begin
         unique case (paddr[5:3])
            REG_GAINS_LEFT:  gains_l_ff  <= pwdata[47:0];
            REG_GAINS_RIGHT: gains_r_ff  <= pwdata[47:0];
            REG_RATE_LIMIT:  rate_lim_ff <= pwdata[15:0];
            REG_INT_CAP:     icap_ff     <= pwdata[30:0];
            REG_INV_RADIUS:  inv_r_ff    <= pwdata[15:0];
            REG_HALF_TRACK:  half_tr_ff  <= pwdata[15:0];
            REG_CPR:         cpr_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         REG_GAINS_LEFT:  prdata = {16'd0, gains_l_ff};
         REG_GAINS_RIGHT: prdata = {16'd0, gains_r_ff};
         REG_RATE_LIMIT:  prdata = {48'd0, rate_lim_ff};
         REG_INT_CAP:     prdata = {33'd0, icap_ff};
         REG_INV_RADIUS:  prdata = {48'd0, inv_r_ff};
         REG_HALF_TRACK:  prdata = {48'd0, half_tr_ff};
         REG_CPR:         prdata = {48'd0, cpr_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------- controller state ----------------
   state_type state_ff, state_in;
   logic      go_ff;

   logic signed [15:0] held_lin_ff, held_lin_in, held_ang_ff, held_ang_in;
   logic [CB-1:0]      lat_ff [2];
   logic [CB-1:0]      lat_in [2];
   logic [CB-1:0]      prv_ff [2];
   logic [CB-1:0]      prv_in [2];
   logic signed [31:0] ist_ff [2];
   logic signed [31:0] ist_in [2];
   logic signed [31:0] perr_ff [2];
   logic signed [31:0] perr_in [2];
   logic [1:0]         stale_ff, stale_in, stale_up;

   // per-tick working registers
   logic [19:0]             us_ff, us_in;
   logic                    sel_ff, sel_in, neg_ff, neg_in;
   logic signed [32:0]      hw_ff, hw_in;
   logic signed [DES_W-1:0] des_ff, des_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic signed [41:0]      est_ff, est_in;
   logic signed [31:0]      err_ff, err_in, integ_ff, integ_in;
   logic signed [51:0]      acc_ff, acc_in;
   logic signed [31:0]      drv_l_ff, drv_l_in, drv_r_ff, drv_r_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // shared serial units
   logic                        mul_start, div_start;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]          mul_b;
   logic [5:0]                  mul_n;
   unit_stat_type               mul_stat, div_stat;
   logic signed [PROD_W-1:0]    mul_prod;
   logic [NUM_W-1:0]            div_num;
   logic [DEN_W-1:0]            div_den;
   logic [6:0]                  div_n;
   logic [QUO_W-1:0]            div_q;
   logic                        div_ovf;

   ddws_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start), .a (mul_a), .b (mul_b),
      .nbits (mul_n), .stat (mul_stat), .prod (mul_prod)
   );

   ddws_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .num (div_num), .den (div_den),
      .nbits (div_n), .stat (div_stat), .quot (div_q), .ovf (div_ovf)
   );

   logic req_acc, est_skip;
   assign req_acc  = req_valid & ~req_stall;
   assign est_skip = (us_ff == 20'd0) || (cpr_ff == 16'd0);

   // ---------------- combinational datapath ----------------
   logic [47:0]             gains;
   logic signed [33:0]      s_val, hw_x;
   logic signed [49:0]      des_p, des_sh, lim50, des_cl;
   logic [CB-1:0]           d_raw, mag;
   logic signed [CB:0]      delta;
   logic [QUO_W-1:0]        est_r;
   logic signed [41:0]      est_val;
   logic signed [43:0]      diff44;
   logic signed [31:0]      err_val, drive_val;
   logic signed [52:0]      ix;
   logic [51:0]             ix_mag;
   logic signed [33:0]      quo34;
   logic signed [34:0]      isum, cap35, isat;
   logic signed [32:0]      ediff;
   logic signed [51:0]      acc_sh;

   always_comb begin
      gains  = sel_ff ? gains_r_ff : gains_l_ff;
      hw_x   = {hw_ff[32], hw_ff};
      s_val  = sel_ff ? {{2{held_lin_ff[15]}}, held_lin_ff, 16'd0} + hw_x
                      : {{2{held_lin_ff[15]}}, held_lin_ff, 16'd0} - hw_x;
      des_p  = mul_prod[49:0];
      des_sh = des_p >>> DES_SH;
      lim50  = $signed(50'(rate_lim_ff) << LIM_SH);
      if (des_sh > lim50) begin
         des_cl = lim50;
      end else if (des_sh < -lim50) begin
         des_cl = -lim50;
      end else begin
         des_cl = des_sh;
      end
      // right wheel count runs opposite to forward motion
      d_raw  = lat_ff[sel_ff] - prv_ff[sel_ff];
      delta  = sel_ff ? -$signed({d_raw[CB-1], d_raw}) : $signed({d_raw[CB-1], d_raw});
      mag    = delta[CB] ? CB'(-delta) : CB'(delta);
      est_r  = (div_ovf || div_q > EST_CAP) ? EST_CAP : div_q;
      est_val = delta[CB] ? -$signed({1'b0, est_r}) : $signed({1'b0, est_r});
      diff44 = {{(44-DES_W){des_ff[DES_W-1]}}, des_ff} - {{2{est_ff[41]}}, est_ff};
      err_val = sat32({{20{diff44[43]}}, diff44});
      // integrator step: floor(err*us / 10^6) on the magnitude
      ix     = mul_prod[52:0];
      ix_mag = ix[52] ? ~ix[51:0] : ix[51:0];
      quo34  = neg_ff ? ~{1'b0, div_q[32:0]} : {1'b0, div_q[32:0]};
      isum   = {{3{ist_ff[sel_ff][31]}}, ist_ff[sel_ff]} + {quo34[33], quo34};
      cap35  = {4'd0, icap_ff};
      if (isum > cap35) begin
         isat = cap35;
      end else if (isum < -cap35) begin
         isat = -cap35;
      end else begin
         isat = isum;
      end
      ediff  = {err_ff[31], err_ff} - {perr_ff[sel_ff][31], perr_ff[sel_ff]};
      acc_sh = acc_ff >>> 8;
      drive_val = sat32({{12{acc_sh[51]}}, acc_sh});
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_acc && req_data.opcode == OP_TICK) state_in = ST_HW;
         ST_HW:      if (mul_stat.done) state_in = ST_DES;
         ST_DES:     if (mul_stat.done) state_in = est_skip ? ST_ERR : ST_EST_DEN;
         ST_EST_DEN: if (mul_stat.done) state_in = ST_EST_NUM;
         ST_EST_NUM: if (mul_stat.done) state_in = ST_EST_DIV;
         ST_EST_DIV: if (div_stat.done) state_in = ST_ERR;
         ST_ERR:     state_in = ST_INT_MUL;
         ST_INT_MUL: if (mul_stat.done) state_in = ST_INT_DIV;
         ST_INT_DIV: if (div_stat.done) state_in = (des_ff == '0) ? ST_FIN : ST_P;
         ST_P:       if (mul_stat.done) state_in = ST_I;
         ST_I:       if (mul_stat.done) state_in = ST_D;
         ST_D:       if (mul_stat.done) state_in = ST_FIN;
         ST_FIN:     state_in = sel_ff ? ST_OUT : ST_DES;
         ST_OUT:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------- unit control outputs ----------------
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_n     = 6'd16;
      div_num   = num_ff;
      div_den   = den_ff;
      div_n     = 7'(NUM_W);
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_HW: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(held_ang_ff);
            mul_b     = {16'd0, half_tr_ff};
         end
         ST_DES: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(s_val);
            mul_b     = {16'd0, inv_r_ff};
         end
         ST_EST_DEN: begin
            mul_start = go_ff;
            mul_a     = $signed({36'd0, us_ff});
            mul_b     = {16'd0, cpr_ff};
         end
         ST_EST_NUM: begin
            mul_start = go_ff;
            mul_a     = $signed({1'b0, EST_C});
            mul_b     = MUL_B_W'(mag);
            mul_n     = 6'(CB);
         end
         ST_EST_DIV: div_start = go_ff;
         ST_INT_MUL: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(err_ff);
            mul_b     = {12'd0, us_ff};
            mul_n     = 6'd20;
         end
         ST_INT_DIV: begin
            div_start = go_ff;
            div_den   = MILLION;
            div_n     = 7'd52;
         end
         ST_P: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(err_ff);
            mul_b     = {16'd0, gains[47:32]};
         end
         ST_I: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(integ_ff);
            mul_b     = {16'd0, gains[31:16]};
         end
         ST_D: begin
            mul_start = go_ff;
            mul_a     = MUL_A_W'(ediff);
            mul_b     = {16'd0, gains[15:0]};
         end
         default: ;
      endcase
   end

   // ---------------- datapath register updates ----------------
   always_comb begin
      held_lin_in  = held_lin_ff;
      held_ang_in  = held_ang_ff;
      lat_in       = lat_ff;
      prv_in       = prv_ff;
      ist_in       = ist_ff;
      perr_in      = perr_ff;
      stale_in     = stale_ff;
      us_in        = us_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      hw_in        = hw_ff;
      des_in       = des_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      est_in       = est_ff;
      err_in       = err_ff;
      integ_in     = integ_ff;
      acc_in       = acc_ff;
      drv_l_in     = drv_l_ff;
      drv_r_in     = drv_r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      stale_up     = (stale_ff == 2'd3) ? 2'd3 : stale_ff + 2'd1;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.opcode)
                  OP_TWIST: begin
                     held_lin_in = req_data.lin_speed;
                     held_ang_in = req_data.ang_speed;
                  end
                  OP_LEFT: begin
                     lat_in[0] = req_data.encoder_count[CB-1:0];
                     stale_in  = 2'd0;
                  end
                  OP_RIGHT: begin
                     lat_in[1] = req_data.encoder_count[CB-1:0];
                     stale_in  = 2'd0;
                  end
                  default: begin
                     us_in  = req_data.elapsed_us;
                     sel_in = 1'b0;
                  end
               endcase
            end
         end
         ST_HW:      if (mul_stat.done) hw_in = mul_prod[32:0];
         ST_DES: begin
            if (mul_stat.done) begin
               des_in = des_cl[DES_W-1:0];
               est_in = '0;
            end
         end
         ST_EST_DEN: begin
            if (mul_stat.done) den_in = DEN_W'(mul_prod[35:0]) << DEN_SH;
         end
         ST_EST_NUM: if (mul_stat.done) num_in = mul_prod[NUM_W-1:0];
         ST_EST_DIV: if (div_stat.done) est_in = est_val;
         ST_ERR:     err_in = err_val;
         ST_INT_MUL: begin
            if (mul_stat.done) begin
               neg_in = ix[52];
               num_in = {ix_mag, 36'd0};
            end
         end
         ST_INT_DIV: if (div_stat.done) integ_in = isat[31:0];
         ST_P:       if (mul_stat.done) acc_in = mul_prod[51:0];
         ST_I, ST_D: if (mul_stat.done) acc_in = acc_ff + mul_prod[51:0];
         ST_FIN: begin
            // zero desired rate: integrator cleared, drive forced to zero
            perr_in[sel_ff] = err_ff;
            ist_in[sel_ff]  = (des_ff == '0) ? 32'sd0 : integ_ff;
            prv_in[sel_ff]  = lat_ff[sel_ff];
            if (sel_ff) begin
               drv_r_in = (des_ff == '0) ? 32'sd0 : drive_val;
            end else begin
               drv_l_in = (des_ff == '0) ? 32'sd0 : drive_val;
            end
            sel_in = 1'b1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.drive_left  = drv_l_ff;
               rsp_in.drive_right = drv_r_ff;
               rsp_valid_in       = 1'b1;
               stale_in           = stale_up;
               // two ticks with no encoder report: drop command and counts
               if (stale_up >= 2'd2) begin
                  held_lin_in = '0;
                  held_ang_in = '0;
                  lat_in[0]   = '0;
                  lat_in[1]   = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         lat_ff[0]    <= '0;
         lat_ff[1]    <= '0;
         prv_ff[0]    <= '0;
         prv_ff[1]    <= '0;
         ist_ff[0]    <= '0;
         ist_ff[1]    <= '0;
         perr_ff[0]   <= '0;
         perr_ff[1]   <= '0;
         stale_ff     <= '0;
         sel_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= (state_in != state_ff);
         rsp_valid_ff <= rsp_valid_in;
         held_lin_ff  <= held_lin_in;
         held_ang_ff  <= held_ang_in;
         lat_ff       <= lat_in;
         prv_ff       <= prv_in;
         ist_ff       <= ist_in;
         perr_ff      <= perr_in;
         stale_ff     <= stale_in;
         sel_ff       <= sel_in;
      end
      us_ff    <= us_in;
      neg_ff   <= neg_in;
      hw_ff    <= hw_in;
      des_ff   <= des_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
      est_ff   <= est_in;
      err_ff   <= err_in;
      integ_ff <= integ_in;
      acc_ff   <= acc_in;
      drv_l_ff <= drv_l_in;
      drv_r_ff <= drv_r_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/ddws_mul.sv @@
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
`timescale 1ns / 1ps
module ddws_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ddws_pkg::MUL_A_W-1:0]   a,
   input  logic [ddws_pkg::MUL_B_W-1:0]          b,
   input  logic [5:0]                            nbits,
   output ddws_pkg::unit_stat_type               stat,
   output logic signed [ddws_pkg::PROD_W-1:0]    prod
);
   import ddws_pkg::*;

   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic signed [PROD_W-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [MUL_B_W-1:0]       b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         acc_in  = '0;
         a_in    = {{(PROD_W-MUL_A_W){a[MUL_A_W-1]}}, a};
         b_in    = b;
         cnt_in  = nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

@@ hdl/ddws_div.sv @@
// Restoring divider, one quotient bit per cycle, saturation flag past the quotient width.
`timescale 1ns / 1ps
module ddws_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ddws_pkg::NUM_W-1:0]     num,
   input  logic [ddws_pkg::DEN_W-1:0]     den,
   input  logic [6:0]                     nbits,
   output ddws_pkg::unit_stat_type        stat,
   output logic [ddws_pkg::QUO_W-1:0]     quot,
   output logic                           ovf
);
   import ddws_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in, ge;
   logic [6:0]         cnt_ff, cnt_in;
   logic [DEN_W:0]     rem_ff, rem_in, trial;
   logic [NUM_W-1:0]   n_ff, n_in;
   logic [DEN_W-1:0]   d_ff, d_in;
   logic [QUO_W-1:0]   q_ff, q_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      trial   = {rem_ff[DEN_W-1:0], n_ff[NUM_W-1]};
      ge      = trial >= {1'b0, d_ff};
      if (start) begin
         rem_in  = '0;
         n_in    = num;
         d_in    = den;
         q_in    = '0;
         ovf_in  = 1'b0;
         cnt_in  = nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, d_ff} : trial;
         q_in   = {q_ff[QUO_W-2:0], ge};
         ovf_in = ovf_ff | q_ff[QUO_W-1];
         n_in   = n_ff << 1;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;
   assign ovf       = ovf_ff;

endmodule

@@ hdl/ddws_checker.sv @@
// Port-level checker for the wheel speed PID block, bound to the top level.
`timescale 1ns / 1ps
`include "diff_drive_wheel_speed_pid_defines.svh"
module ddws_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input ddws_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ddws_pkg::rsp_type  rsp_data,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [5:0]         paddr,
   input logic [63:0]        pwdata,
   input logic [63:0]        prdata,
   input logic               pready
);
   import ddws_pkg::*;

   logic req_beat, tick_beat;
   assign req_beat  = req_valid & ~req_stall;
   assign tick_beat = req_beat & (req_data.opcode == OP_TICK);

   `DDWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed")
   `DDWS_ASSERT_NEXT(a_tick_busy, clock, reset, tick_beat, req_stall, "tick beat did not start computation")
   `DDWS_ASSERT_NEXT(a_event_quick, clock, reset, req_beat && !tick_beat, !req_stall, "event beat left block busy")
   `DDWS_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind diff_drive_wheel_speed_pid ddws_checker u_ddws_checker (.*);

@@ dv/diff_drive_wheel_speed_pid_test.sv @@
// Testbench for the differential drive wheel speed PID block.
`timescale 1ns / 1ps
module diff_drive_wheel_speed_pid_test;
   import ddws_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam logic [2:0] REG_UNUSED = 3'd7;   // beyond the register list, write is dropped
   localparam longint DRIVE_MAX = 64'sd2147483647;
   localparam longint DRIVE_MIN = -64'sd2147483648;
   localparam longint RATE_CAP = 64'sd1099511627776;   // 2^40

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   diff_drive_wheel_speed_pid DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // -------------------------------------------------------------------------
   // Shadow copy of the block: registers and controller state
   // -------------------------------------------------------------------------
   logic [47:0] cfg_gains [2];
   logic [15:0] cfg_rate_limit;
   logic [30:0] cfg_int_cap;
   logic [15:0] cfg_inv_radius;
   logic [15:0] cfg_half_track;
   logic [15:0] cfg_cpr;

   longint      cmd_lin, cmd_ang;
   logic [31:0] enc_latched [2];
   logic [31:0] enc_prev [2];
   longint      integ_acc [2];
   longint      last_err [2];
   int          stale_count;

   rsp_type     drive_queue [$];   // drive values still owed by the block
   int          mismatches;
   bit          pressure_req;      // asks the stall process for one long hold-off

   function automatic longint sat_word(longint x);
      if (x > DRIVE_MAX) return DRIVE_MAX;
      if (x < DRIVE_MIN) return DRIVE_MIN;
      return x;
   endfunction

   // floor division by a positive constant
   function automatic longint floor_div(longint x, longint d);
      longint q;
      q = x / d;
      if (x < 0 && q * d != x) q = q - 1;
      return q;
   endfunction

   // One wheel's PID update; k = 0 left, 1 right
   function automatic longint wheel_drive(int k, longint desired, longint us);
      logic [31:0]  diff;
      longint       delta, est, err, integ, acc, kp, ki, kd, cap;
      logic [127:0] num, den, quo;
      diff  = enc_latched[k] - enc_prev[k];
      delta = longint'($signed(diff));
      enc_prev[k] = enc_latched[k];
      if (k == 1) delta = -delta;
      est = 0;
      if (us != 0 && cfg_cpr != 0) begin
         num = 128'(delta < 0 ? -delta : delta) * 128'(EST_C);
         den = (128'(cfg_cpr) * 128'(us)) << 16;
         quo = num / den;
         est = (quo > 128'(RATE_CAP)) ? RATE_CAP : longint'(quo);
         if (delta < 0) est = -est;
      end
      kp  = longint'(cfg_gains[k][47:32]);
      ki  = longint'(cfg_gains[k][31:16]);
      kd  = longint'(cfg_gains[k][15:0]);
      cap = longint'(cfg_int_cap);
      err = sat_word(desired - est);
      integ = integ_acc[k] + floor_div(err * us, 1000000);
      if (integ > cap) integ = cap;
      if (integ < -cap) integ = -cap;
      acc = 0;
      if (desired == 0) begin
         integ = 0;
      end else begin
         acc = sat_word((kp * err + ki * integ + kd * (err - last_err[k])) >>> 8);
      end
      last_err[k]  = err;
      integ_acc[k] = integ;
      return acc;
   endfunction

   // Apply one accepted beat to the shadow state; ticks queue their drive pair
   function automatic void predict_beat(req_type b);
      longint  hw, lim, want [2];
      rsp_type r;
      case (opcode_type'(b.opcode))
         OP_TWIST: begin
            cmd_lin = longint'(b.lin_speed);
            cmd_ang = longint'(b.ang_speed);
         end
         OP_LEFT: begin
            enc_latched[0] = b.encoder_count;
            stale_count = 0;
         end
         OP_RIGHT: begin
            enc_latched[1] = b.encoder_count;
            stale_count = 0;
         end
         default: begin
            hw  = longint'(cfg_half_track) * cmd_ang;
            lim = longint'(cfg_rate_limit) << 8;
            want[0] = cmd_lin * 65536 - hw;
            want[1] = cmd_lin * 65536 + hw;
            for (int k = 0; k < 2; k++) begin
               want[k] = (want[k] * longint'(cfg_inv_radius)) >>> 20;
               if (want[k] > lim) want[k] = lim;
               if (want[k] < -lim) want[k] = -lim;
            end
            r.drive_left  = 32'(wheel_drive(0, want[0], longint'(b.elapsed_us)));
            r.drive_right = 32'(wheel_drive(1, want[1], longint'(b.elapsed_us)));
            if (stale_count < 3) stale_count++;
            // two ticks with no encoder news: drop commands and counts
            if (stale_count >= 2) begin
               cmd_lin = 0;
               cmd_ang = 0;
               enc_latched[0] = '0;
               enc_latched[1] = '0;
            end
            drive_queue.push_back(r);
         end
      endcase
   endfunction

   task automatic report(string what, longint got, longint want);
      mismatches++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // -------------------------------------------------------------------------
   // Clock, limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // generous cap, several times the slowest legal run
   initial begin
      #30ms;
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: random stall, plus one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      int pick, len;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (pressure_req) begin
            // long hold-off so the block backs up into the request side
            pressure_req = 1'b0;
            rsp_stall = 1'b1;
            for (int n = 0; n < 3000; n++) @(negedge clock);
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            rsp_stall = 1'b0;
            len = $urandom_range(1, 40);
         end else if (pick < 9) begin
            rsp_stall = 1'b1;
            len = $urandom_range(1, 4);
         end else begin
            rsp_stall = 1'b1;
            len = $urandom_range(20, 200);
         end
         repeat (len) @(negedge clock);
      end
   end

   // Result checker: each accepted beat against the oldest owed pair
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_queue.size() == 0) begin
            report("unexpected result drive_left", rsp_data.drive_left, 0);
         end else begin
            want = drive_queue.pop_front();
            if (rsp_data.drive_left !== want.drive_left)
               report("drive_left", rsp_data.drive_left, want.drive_left);
            if (rsp_data.drive_right !== want.drive_right)
               report("drive_right", rsp_data.drive_right, want.drive_right);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side and register port
   // -------------------------------------------------------------------------
   task automatic send_beat(req_type b);
      int pick, gap;
      req_valid = 1'b1;
      req_data  = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(b);
      @(negedge clock);
      pick = $urandom_range(0, 9);
      gap = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(20, 100);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Let every owed result drain, then let a trailing non-tick beat settle
   task automatic drain;
      req_valid = 1'b0;
      while (drive_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic reg_write(logic [2:0] idx, logic [63:0] value);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = {idx, 3'b000}; pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_GAINS_LEFT:  cfg_gains[0]   = value[47:0];
         REG_GAINS_RIGHT: cfg_gains[1]   = value[47:0];
         REG_RATE_LIMIT:  cfg_rate_limit = value[15:0];
         REG_INT_CAP:     cfg_int_cap    = value[30:0];
         REG_INV_RADIUS:  cfg_inv_radius = value[15:0];
         REG_HALF_TRACK:  cfg_half_track = value[15:0];
         REG_CPR:         cfg_cpr        = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic load_setting(logic [47:0] gl, logic [47:0] gr, logic [15:0] lim,
                               logic [30:0] cap, logic [15:0] inv, logic [15:0] half,
                               logic [15:0] cpr);
      reg_write(REG_GAINS_LEFT, 64'(gl));
      reg_write(REG_GAINS_RIGHT, 64'(gr));
      reg_write(REG_RATE_LIMIT, 64'(lim));
      reg_write(REG_INT_CAP, 64'(cap));
      reg_write(REG_INV_RADIUS, 64'(inv));
      reg_write(REG_HALF_TRACK, 64'(half));
      reg_write(REG_CPR, 64'(cpr));
   endtask

   function automatic req_type make_beat(opcode_type op, int lin, int ang, int cnt, int us);
      req_type b;
      b.opcode        = op;
      b.lin_speed     = 16'(lin);
      b.ang_speed     = 16'(ang);
      b.encoder_count = 32'(cnt);
      b.elapsed_us    = 20'(us);
      return b;
   endfunction

   // Random beats with payload bits scattered in unused fields
   function automatic req_type noise_beat();
      req_type b;
      b = req_type'({$urandom, $urandom, $urandom});
      return b;
   endfunction

   // Directed table: the typed-in pair is used where the answer is obvious
   typedef struct {
      req_type beat;
      bit      fixed;
      rsp_type pair;
   } row_type;

   row_type dir_rows [$];

   function automatic void add_row(req_type b, bit fixed = 1'b0);
      row_type r;
      r.beat  = b;
      r.fixed = fixed;
      r.pair  = '0;
      dir_rows.push_back(r);
   endfunction

   initial begin
      int         tracked [2];
      int         pick, items, us;
      req_type    b;

      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      pressure_req = 1'b0;
      mismatches = 0;
      cfg_gains[0] = '0; cfg_gains[1] = '0;
      cfg_rate_limit = 16'hffff; cfg_int_cap = 31'h7fffffff;
      cfg_inv_radius = 16'd5120; cfg_half_track = 16'd7209; cfg_cpr = 16'd1185;
      cmd_lin = 0; cmd_ang = 0; stale_count = 0;
      for (int k = 0; k < 2; k++) begin
         enc_latched[k] = '0; enc_prev[k] = '0; integ_acc[k] = 0; last_err[k] = 0;
         tracked[k] = 0;
      end
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // tick straight out of reset: no command, zero drive whatever the gains
      add_row(make_beat(OP_TICK, 0, 0, 0, 100000), 1'b1);
      add_row(make_beat(OP_TWIST, 32767, 0, 0, 0));
      add_row(make_beat(OP_LEFT, 0, 0, 1000, 0));
      add_row(make_beat(OP_RIGHT, 0, 0, -1000, 0));
      add_row(make_beat(OP_TICK, 0, 0, 0, 100000));
      add_row(make_beat(OP_TWIST, -32768, 32767, 0, 0));
      add_row(make_beat(OP_LEFT, 0, 0, 2147483647, 0));
      add_row(make_beat(OP_RIGHT, 0, 0, -2147483648, 0));
      add_row(make_beat(OP_TICK, 0, 0, 0, 0));          // zero elapsed: no rate estimate
      add_row(make_beat(OP_TWIST, 1200, -32768, 0, 0));
      add_row(make_beat(OP_LEFT, 0, 0, -2147483648, 0));
      add_row(make_beat(OP_RIGHT, 0, 0, 2147483647, 0));
      add_row(make_beat(OP_TICK, 0, 0, 0, 1048575));
      add_row(make_beat(OP_TICK, 0, 0, 0, 1));          // stale, commands cleared after
      add_row(make_beat(OP_TICK, 0, 0, 0, 50000), 1'b1);  // cleared command: zero drive
      add_row(make_beat(OP_TWIST, 0, 0, 0, 0));
      add_row(make_beat(OP_LEFT, 0, 0, 0, 0));
      add_row(make_beat(OP_TICK, 0, 0, 0, 100000), 1'b1); // zero command: zero drive
      add_row(make_beat(OP_TWIST, 4096, 2048, 0, 0));
      add_row(make_beat(OP_LEFT, 0, 0, 300, 0));
      add_row(make_beat(OP_RIGHT, 0, 0, -280, 0));
      add_row(make_beat(OP_TICK, 0, 0, 0, 100000));

      load_setting(48'h0200_0080_0040, 48'h0180_0100_0020, 16'hffff, 31'h7fffffff,
                   16'd5120, 16'd7209, 16'd1185);
      reg_write(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].beat);
         if (dir_rows[i].fixed) begin
            // swap the prediction for the pair read off at a glance
            void'(drive_queue.pop_back());
            drive_queue.push_back(dir_rows[i].pair);
         end
      end
      tracked[0] = 0;
      tracked[1] = 0;

      // Random part: phases over several register settings, extremes included
      items = 0;
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: load_setting(48'h0100_0040_0020, 48'h0100_0040_0020, 16'd2560, 31'd6553600,
                            16'd5120, 16'd7209, 16'd1185);
            1: load_setting(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 16'hffff, 31'h7fffffff,
                            16'hffff, 16'hffff, 16'd1);
            2: load_setting(48'h0, 48'h0001_0001_0001, 16'd0, 31'd0, 16'd1, 16'd0, 16'hffff);
            default: load_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  16'($urandom), 31'($urandom),
                                  16'($urandom_range(1, 65535)), 16'($urandom),
                                  16'($urandom_range(1, 65535)));
         endcase
         for (int n = 0; n < 25; n++) begin
            if (phase == 4 && n == 5) pressure_req = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               // well-formed round: twist, encoders, tick
               if ($urandom_range(0, 2) != 0) begin
                  if ($urandom_range(0, 1))
                     b = make_beat(OP_TWIST, $urandom_range(0, 4096) - 2048,
                                   $urandom_range(0, 4096) - 2048, $urandom, $urandom);
                  else
                     b = make_beat(OP_TWIST, $urandom, $urandom, $urandom, $urandom);
                  send_beat(b); items++;
               end
               for (int k = 0; k < 2; k++) begin
                  if ($urandom_range(0, 5) != 0) begin
                     if ($urandom_range(0, 9) == 0) tracked[k] = $urandom;
                     else tracked[k] = tracked[k] + $urandom_range(0, 6000) - 3000;
                     b = make_beat(k == 0 ? OP_LEFT : OP_RIGHT, $urandom, $urandom,
                                   tracked[k], $urandom);
                     send_beat(b); items++;
                  end
               end
               case ($urandom_range(0, 9))
                  0:       us = 0;
                  1:       us = 1048575;
                  2:       us = $urandom_range(0, 1048575);
                  default: us = $urandom_range(50000, 150000);
               endcase
               b = make_beat(OP_TICK, $urandom, $urandom, $urandom, us);
               send_beat(b); items++;
            end else begin
               // noise: any opcode, any payload
               send_beat(noise_beat()); items++;
            end
         end
      end
      // keep going until the item count is reached
      while (items < 580) begin
         b = noise_beat();
         if ($urandom_range(0, 3) == 0) b.opcode = OP_TICK;
         send_beat(b); items++;
      end

      req_valid = 1'b0;
      while (drive_queue.size() != 0) @(negedge clock);
      repeat (700) @(negedge clock);
      if (mismatches == 0 && drive_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
